/* rtl/avr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, angle table and stage types for the axis vector rotation block.
package avr_pkg;

   // Coordinate and angle formats
   localparam int COORD_W = 32;
   localparam int ANGLE_W = 16;
   localparam int OP_W    = 2;

   // CORDIC datapath
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 30;
   localparam int CW            = 34;   // x/y working width, Q2.30 with headroom
   localparam int ZW            = 34;   // angle accumulator, 2^32 units per turn
   localparam int CS_FRAC       = 30;   // fraction bits of cos/sin

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [ZW-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81,
      34'sd41,        34'sd20,        34'sd10,        34'sd5,
      34'sd3,         34'sd1
   };

   // Rotation axis codes
   localparam logic [OP_W-1:0] OP_ROT_X = 2'd0;
   localparam logic [OP_W-1:0] OP_ROT_Y = 2'd1;
   localparam logic [OP_W-1:0] OP_ROT_Z = 2'd2;
   localparam logic [OP_W-1:0] OP_PASS  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           opcode;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
   } avr_point_type;

   typedef struct packed {
      logic [1:0]           quad;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      avr_point_type        pt;
   } avr_cordic_type;

endpackage

/* rtl/avr_cordic.sv */
`timescale 1ns / 1ps
// Unrolled rotation-mode CORDIC: quadrant reduction and one micro-rotation per stage.
module avr_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  avr_pkg::avr_point_type        in_pt,
   input  logic [avr_pkg::ANGLE_W-1:0]   in_angle,
   output logic                          out_valid,
   output avr_pkg::avr_cordic_type       out_cs
);
   import avr_pkg::*;

   avr_cordic_type             stage_ff [CORDIC_STAGES];
   avr_cordic_type             stage_in [CORDIC_STAGES];
   logic [CORDIC_STAGES-1:0]   valid_ff;
   avr_cordic_type             head;
   logic [ANGLE_W-1:0]         angle_bias;
   logic [ANGLE_W-1:0]         resid;

   // reduce the angle to a quadrant and a residual in [-1/8, +1/8) turn
   always_comb begin
      angle_bias = in_angle + 16'h2000;
      head.quad  = angle_bias[ANGLE_W-1:ANGLE_W-2];
      resid      = in_angle - {head.quad, {(ANGLE_W-2){1'b0}}};
      head.x     = CORDIC_GAIN;
      head.y     = '0;
      head.z     = {{(ZW-ANGLE_W-16){resid[ANGLE_W-1]}}, resid, 16'h0000};
      head.pt    = in_pt;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      avr_cordic_type       prev;
      logic                 prev_valid;
      logic signed [CW-1:0] px_s;
      logic signed [CW-1:0] py_s;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;

      if (i == 0) begin : g_first
         assign prev       = head;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev       = stage_ff[i-1];
         assign prev_valid = valid_ff[i-1];
      end

      assign px_s = prev.x;
      assign py_s = prev.y;
      assign dx   = py_s >>> i;
      assign dy   = px_s >>> i;

      always_comb begin
         stage_in[i] = prev;
         if (!prev.z[ZW-1]) begin
            stage_in[i].x = px_s - dx;
            stage_in[i].y = py_s + dy;
            stage_in[i].z = prev.z - ATAN_TURNS[i];
         end else begin
            stage_in[i].x = px_s + dx;
            stage_in[i].y = py_s - dy;
            stage_in[i].z = prev.z + ATAN_TURNS[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STAGES-1];
   assign out_cs    = stage_ff[CORDIC_STAGES-1];

endmodule

/* rtl/avr_rotate.sv */
`timescale 1ns / 1ps
// Quadrant mapping, products, sums and rounding with saturation of the rotated point.
module avr_rotate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  avr_pkg::avr_cordic_type             in_cs,
   output logic                                out_valid,
   output logic signed [avr_pkg::COORD_W-1:0]  out_rx,
   output logic signed [avr_pkg::COORD_W-1:0]  out_ry,
   output logic signed [avr_pkg::COORD_W-1:0]  out_rz
);
   import avr_pkg::*;

   localparam int PW = CW + COORD_W;
   localparam int SW = PW + 1;
   localparam int RW = SW - CS_FRAC;
   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (CS_FRAC - 1);

   // map stage
   logic                      map_valid_ff;
   logic signed [CW-1:0]      map_c_ff, map_s_ff, map_c_in, map_s_in;
   logic signed [COORD_W-1:0] map_u_ff, map_v_ff, map_u_in, map_v_in;
   avr_point_type             map_pt_ff;
   logic signed [CW-1:0]      cs_x, cs_y;

   // product stage
   logic                      mul_valid_ff;
   logic signed [PW-1:0]      mul_cu_ff, mul_sv_ff, mul_su_ff, mul_cv_ff;
   avr_point_type             mul_pt_ff;

   // sum stage
   logic                      sum_valid_ff;
   logic signed [SW-1:0]      sum_a_ff, sum_b_ff;
   avr_point_type             sum_pt_ff;

   // output stage
   logic                      out_valid_ff;
   logic signed [COORD_W-1:0] out_rx_ff, out_ry_ff, out_rz_ff;
   logic signed [COORD_W-1:0] out_rx_in, out_ry_in, out_rz_in;
   logic signed [SW-1:0]      rnd_a, rnd_b;
   logic signed [COORD_W-1:0] sat_a, sat_b;

   function automatic logic signed [COORD_W-1:0] saturate(input logic [RW-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[RW-1:COORD_W-1] == {(RW-COORD_W+1){v[RW-1]}}) begin
         r = v[COORD_W-1:0];
      end else if (v[RW-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign cs_x = in_cs.x;
   assign cs_y = in_cs.y;

   always_comb begin
      case (in_cs.quad)
         2'd0: begin
            map_c_in = cs_x;
            map_s_in = cs_y;
         end
         2'd1: begin
            map_c_in = -cs_y;
            map_s_in = cs_x;
         end
         2'd2: begin
            map_c_in = -cs_x;
            map_s_in = -cs_y;
         end
         default: begin
            map_c_in = cs_y;
            map_s_in = -cs_x;
         end
      endcase
      case (in_cs.pt.opcode)
         OP_ROT_X: begin
            map_u_in = in_cs.pt.py;
            map_v_in = in_cs.pt.pz;
         end
         OP_ROT_Y: begin
            map_u_in = in_cs.pt.pz;
            map_v_in = in_cs.pt.px;
         end
         default: begin
            map_u_in = in_cs.pt.px;
            map_v_in = in_cs.pt.py;
         end
      endcase
   end

   // round half up, floor shift back to the coordinate format
   assign rnd_a = sum_a_ff + ROUND_HALF;
   assign rnd_b = sum_b_ff + ROUND_HALF;
   assign sat_a = saturate(rnd_a[SW-1:CS_FRAC]);
   assign sat_b = saturate(rnd_b[SW-1:CS_FRAC]);

   always_comb begin
      out_rx_in = sum_pt_ff.px;
      out_ry_in = sum_pt_ff.py;
      out_rz_in = sum_pt_ff.pz;
      case (sum_pt_ff.opcode)
         OP_ROT_X: begin
            out_ry_in = sat_a;
            out_rz_in = sat_b;
         end
         OP_ROT_Y: begin
            out_rz_in = sat_a;
            out_rx_in = sat_b;
         end
         OP_ROT_Z: begin
            out_rx_in = sat_a;
            out_ry_in = sat_b;
         end
         default: begin
            out_rx_in = sum_pt_ff.px;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         map_valid_ff <= in_valid;
         mul_valid_ff <= map_valid_ff;
         sum_valid_ff <= mul_valid_ff;
         out_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         map_c_ff  <= map_c_in;
         map_s_ff  <= map_s_in;
         map_u_ff  <= map_u_in;
         map_v_ff  <= map_v_in;
         map_pt_ff <= in_cs.pt;

         mul_cu_ff <= map_c_ff * map_u_ff;
         mul_sv_ff <= map_s_ff * map_v_ff;
         mul_su_ff <= map_s_ff * map_u_ff;
         mul_cv_ff <= map_c_ff * map_v_ff;
         mul_pt_ff <= map_pt_ff;

         sum_a_ff  <= SW'(mul_cu_ff) - SW'(mul_sv_ff);
         sum_b_ff  <= SW'(mul_su_ff) + SW'(mul_cv_ff);
         sum_pt_ff <= mul_pt_ff;

         out_rx_ff <= out_rx_in;
         out_ry_ff <= out_ry_in;
         out_rz_ff <= out_rz_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rx    = out_rx_ff;
   assign out_ry    = out_ry_ff;
   assign out_rz    = out_rz_ff;

endmodule

/* rtl/axis_vector_rotation_top.sv */
`timescale 1ns / 1ps
// Top level of the axis vector rotation block: stream ports, input register, stall control.
//
// Rotates a Q16.16 point about the X, Y or Z axis by a 16-bit binary angle
// (65536 = one turn). Axis code 3 passes the point through unchanged.
// Request channel (req_*): tdata carries the point and the angle, tuser the
// axis code. A request is taken on a rising edge with tvalid and tready high.
// Response channel (rsp_*): tdata carries the rotated point, saturated to
// the 32-bit range, one response per request, in request order.
// Pipeline from request to rsp_tvalid: one input register, one register per
// CORDIC micro-rotation (16 CORDIC stages), then quadrant mapping, products,
// sums, and rounding into the output register.
// Throughput: one request per cycle unless the output stalls; the unrolled CORDIC
// chain and the four parallel 34x32 multipliers take a new operand set every advancing cycle.
// Stall: while a response waits with rsp_tready low, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated. Empty slots in
// the pipeline keep moving only when the output is free.
// Reset: synchronous, active high; clears all valid bits, so the pipeline
// comes up empty with rsp_tvalid low.
module axis_vector_rotation_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,    // px[31:0], py[63:32], pz[95:64], turn_angle[111:96]
   input  logic [1:0]    req_tuser,    // opcode[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata     // rx[31:0], ry[63:32], rz[95:64]
);
   import avr_pkg::*;

   logic                      advance;
   logic                      in_valid_ff;
   avr_point_type             in_pt_ff, in_pt_in;
   logic [ANGLE_W-1:0]        in_angle_ff;
   logic                      cordic_valid;
   avr_cordic_type            cordic_cs;
   logic signed [COORD_W-1:0] rx, ry, rz;

   // advance every stage together whenever the output register is free
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // unpack the request
   assign in_pt_in.opcode = req_tuser;
   assign in_pt_in.px     = req_tdata[31:0];
   assign in_pt_in.py     = req_tdata[63:32];
   assign in_pt_in.pz     = req_tdata[95:64];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // hold payload with the stall; no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         in_pt_ff    <= in_pt_in;
         in_angle_ff <= req_tdata[111:96];
      end
   end

   avr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (in_valid_ff),
      .in_pt     (in_pt_ff),
      .in_angle  (in_angle_ff),
      .out_valid (cordic_valid),
      .out_cs    (cordic_cs)
   );

   avr_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (cordic_valid),
      .in_cs     (cordic_cs),
      .out_valid (rsp_tvalid),
      .out_rx    (rx),
      .out_ry    (ry),
      .out_rz    (rz)
   );

   // pack the response
   assign rsp_tdata = {rz, ry, rx};

endmodule
